### rtl/qfcp_pkg.sv
// ----------------------------------------------------------------------------
// Quadtree fractal code parser package
// Shared types, register map, command and status bundles between the
// controller, the datapath and the register block.
// ----------------------------------------------------------------------------
package qfcp_pkg;

   // Fixed field widths.
   localparam int COORD_W    = 12;
   localparam int SIZE_W     = 13;
   localparam int EXP_W      = 5;
   localparam int FIELD_W    = 15;
   localparam int DOM_W      = 18;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   // Default tree depth bound.
   localparam int DEF_MAX_LEVELS = 12;

   // Last step of the start-up sweep over candidate exponents.
   localparam logic [3:0] SWEEP_LAST = 4'd12;

   // Register reset values.
   localparam logic [3:0]  RST_SCALE_BITS  = 4'd5;
   localparam logic [3:0]  RST_OFFSET_BITS = 4'd7;
   localparam logic [6:0]  RST_MIN_BLOCK   = 7'd4;
   localparam logic [6:0]  RST_MAX_BLOCK   = 7'd16;
   localparam logic [5:0]  RST_DOMAIN_STEP = 6'd1;
   localparam logic [11:0] RST_IMAGE_COLS  = 12'd256;
   localparam logic [11:0] RST_IMAGE_ROWS  = 12'd256;
   localparam logic        RST_COLOR_MODE  = 1'b0;

   // Register indexes.
   typedef enum logic [2:0] {
      REG_SCALE_BITS  = 3'd0,
      REG_OFFSET_BITS = 3'd1,
      REG_MIN_BLOCK   = 3'd2,
      REG_MAX_BLOCK   = 3'd3,
      REG_DOMAIN_STEP = 3'd4,
      REG_IMAGE_COLS  = 3'd5,
      REG_IMAGE_ROWS  = 3'd6,
      REG_COLOR_MODE  = 3'd7
   } reg_idx_type;

   typedef struct packed {
      logic [3:0]  scale_bits;
      logic [3:0]  offset_bits;
      logic [6:0]  min_block;
      logic [6:0]  max_block;
      logic [5:0]  domain_step;
      logic [11:0] image_cols;
      logic [11:0] image_rows;
      logic        color_mode;
   } cfg_type;

   // Datapath operations.
   typedef enum logic [2:0] {
      OP_NONE,
      OP_CLEAR,
      OP_SWEEP,
      OP_SETTLE,
      OP_ADVANCE,
      OP_LOAD,
      OP_BIT,
      OP_EMIT
   } op_type;

   typedef enum logic [1:0] {
      SK_DONE,
      SK_OUT,
      SK_DESCEND,
      SK_STOP
   } settle_kind_type;

   typedef enum logic [1:0] {
      AK_STEP,
      AK_POP,
      AK_DONE
   } adv_kind_type;

   typedef enum logic [1:0] {
      BK_NEXT,
      BK_DESCEND,
      BK_EMIT
   } bit_kind_type;

   typedef struct packed {
      op_type op;
      logic   show;
   } cmd_type;

   typedef struct packed {
      settle_kind_type settle_kind;
      adv_kind_type    adv_kind;
      bit_kind_type    bit_kind;
      logic            bits_left;
      logic            bits_last;
      logic            walk_done;
      logic            out_busy;
      logic            sweep_last;
   } sts_type;

endpackage

### rtl/qfcp_csr.sv
// ----------------------------------------------------------------------------
// Quadtree fractal code parser register block
// Holds the configuration registers behind the APB-style port and flags
// every completed write so that the walk restarts.
// ----------------------------------------------------------------------------
module qfcp_csr
   import qfcp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg,
   output logic                  csr_write
);

   cfg_type     cfg_ff;
   cfg_type     cfg_in;
   reg_idx_type idx;

   assign idx       = reg_idx_type'(paddr[4:2]);
   assign csr_write = psel & penable & pwrite;
   assign pready    = 1'b1;
   assign cfg       = cfg_ff;

   // Register write decode.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (idx)
            REG_SCALE_BITS:  cfg_in.scale_bits  = pwdata[3:0];
            REG_OFFSET_BITS: cfg_in.offset_bits = pwdata[3:0];
            REG_MIN_BLOCK:   cfg_in.min_block   = pwdata[6:0];
            REG_MAX_BLOCK:   cfg_in.max_block   = pwdata[6:0];
            REG_DOMAIN_STEP: cfg_in.domain_step = pwdata[5:0];
            REG_IMAGE_COLS:  cfg_in.image_cols  = pwdata[11:0];
            REG_IMAGE_ROWS:  cfg_in.image_rows  = pwdata[11:0];
            REG_COLOR_MODE:  cfg_in.color_mode  = pwdata[0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   // Read-back multiplexer.
   always_comb begin
      case (idx)
         REG_SCALE_BITS:  prdata = CSR_DATA_W'(cfg_ff.scale_bits);
         REG_OFFSET_BITS: prdata = CSR_DATA_W'(cfg_ff.offset_bits);
         REG_MIN_BLOCK:   prdata = CSR_DATA_W'(cfg_ff.min_block);
         REG_MAX_BLOCK:   prdata = CSR_DATA_W'(cfg_ff.max_block);
         REG_DOMAIN_STEP: prdata = CSR_DATA_W'(cfg_ff.domain_step);
         REG_IMAGE_COLS:  prdata = CSR_DATA_W'(cfg_ff.image_cols);
         REG_IMAGE_ROWS:  prdata = CSR_DATA_W'(cfg_ff.image_rows);
         REG_COLOR_MODE:  prdata = CSR_DATA_W'(cfg_ff.color_mode);
         default:         prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.scale_bits  <= RST_SCALE_BITS;
         cfg_ff.offset_bits <= RST_OFFSET_BITS;
         cfg_ff.min_block   <= RST_MIN_BLOCK;
         cfg_ff.max_block   <= RST_MAX_BLOCK;
         cfg_ff.domain_step <= RST_DOMAIN_STEP;
         cfg_ff.image_cols  <= RST_IMAGE_COLS;
         cfg_ff.image_rows  <= RST_IMAGE_ROWS;
         cfg_ff.color_mode  <= RST_COLOR_MODE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### rtl/qfcp_dp.sv
// ----------------------------------------------------------------------------
// Quadtree fractal code parser datapath
// Bit shifter, field assembler, tree position and child stack, start-up
// exponent sweep and the result register. Driven one operation a cycle.
// ----------------------------------------------------------------------------
module qfcp_dp
   import qfcp_pkg::*;
#(
   parameter int MAX_LEVELS = DEF_MAX_LEVELS
)
(
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  cmd_type            cmd,
   input  logic [7:0]         req_stream_byte,
   input  logic               rsp_stall,
   output sts_type            sts,
   output logic               rsp_valid,
   output logic [COORD_W-1:0] rsp_block_row,
   output logic [COORD_W-1:0] rsp_block_col,
   output logic [6:0]         rsp_block_size,
   output logic [FIELD_W-1:0] rsp_scale_code,
   output logic [FIELD_W-1:0] rsp_offset_code,
   output logic [7:0]         rsp_chroma_u,
   output logic [7:0]         rsp_chroma_v,
   output logic [2:0]         rsp_isometry,
   output logic [DOM_W-1:0]   rsp_domain_row,
   output logic [DOM_W-1:0]   rsp_domain_col,
   output logic               rsp_last
);

   localparam int LW = $clog2(MAX_LEVELS + 1);
   localparam int IW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;

   typedef enum logic [3:0] {
      PH_SPLIT,
      PH_SCALE,
      PH_OFFSET,
      PH_U,
      PH_V,
      PH_ISO,
      PH_DROW,
      PH_DCOL,
      PH_EMIT,
      PH_DONE
   } phase_type;

   // Parse state.
   logic [7:0]         buf_ff, buf_in;
   logic [3:0]         rem_ff, rem_in;
   logic [FIELD_W-1:0] acc_ff, acc_in;
   logic [3:0]         idx_ff, idx_in;
   phase_type          phase_ff, phase_in;
   logic [1:0]         stack_ff [MAX_LEVELS];
   logic [1:0]         stack_in [MAX_LEVELS];
   logic [LW-1:0]      level_ff, level_in;
   logic [COORD_W-1:0] row_ff, row_in, col_ff, col_in;
   logic               done_ff, done_in;

   // Record being assembled.
   logic [FIELD_W-1:0] scale_ff, scale_in, offs_ff, offs_in;
   logic [15:0]        chroma_ff, chroma_in;
   logic [2:0]         iso_ff, iso_in;
   logic [DOM_W-1:0]   drow_ff, drow_in, dcol_ff, dcol_in;

   // Exponents found by the start-up sweep.
   logic [3:0] sweep_ff, sweep_in;
   logic [3:0] exp_ff, exp_in, wrow_ff, wrow_in, wcol_ff, wcol_in;
   logic       expf_ff, expf_in, wrowf_ff, wrowf_in, wcolf_ff, wcolf_in;

   // Result register.
   logic               ovalid_ff, ovalid_in, olast_ff, olast_in;
   logic [COORD_W-1:0] orow_ff, orow_in, ocol_ff, ocol_in;
   logic [6:0]         osize_ff, osize_in;
   logic [FIELD_W-1:0] oscale_ff, oscale_in, ooffs_ff, ooffs_in;
   logic [15:0]        ochroma_ff, ochroma_in;
   logic [2:0]         oiso_ff, oiso_in;
   logic [DOM_W-1:0]   odrow_ff, odrow_in, odcol_ff, odcol_in;

   // Effective configuration, a zero acting as one.
   logic [11:0] rows_e, cols_e, span;
   logic [6:0]  minb_e, maxb_e;
   logic [5:0]  step_e;
   logic [3:0]  sbits_e, obits_e;

   assign rows_e  = (cfg.image_rows == '0) ? 12'd1 : cfg.image_rows;
   assign cols_e  = (cfg.image_cols == '0) ? 12'd1 : cfg.image_cols;
   assign span    = (rows_e > cols_e) ? rows_e : cols_e;
   assign minb_e  = (cfg.min_block == '0) ? 7'd1 : cfg.min_block;
   assign maxb_e  = (cfg.max_block == '0) ? 7'd1 : cfg.max_block;
   assign step_e  = (cfg.domain_step == '0) ? 6'd1 : cfg.domain_step;
   assign sbits_e = (cfg.scale_bits == '0) ? 4'd1 : cfg.scale_bits;
   assign obits_e = (cfg.offset_bits == '0) ? 4'd1 : cfg.offset_bits;

   // Node size at the current level.
   logic [EXP_W-1:0]  exp_cap, lvl5;
   logic [SIZE_W-1:0] size;
   logic [11:0]       half;
   logic              at_max;

   assign exp_cap = (EXP_W'(exp_ff) > EXP_W'(MAX_LEVELS)) ?
                    EXP_W'(MAX_LEVELS) : EXP_W'(exp_ff);
   assign lvl5    = EXP_W'(level_ff);
   assign size    = (lvl5 <= exp_cap) ? (SIZE_W'(1) << (exp_cap - lvl5)) : '0;
   assign half    = size[11:0];
   assign at_max  = (level_ff == LW'(MAX_LEVELS));

   // Placement of the current node against the image.
   logic [13:0] row_end, col_end;
   logic        outside, forced, want_split;

   assign row_end    = 14'(row_ff) + 14'(size);
   assign col_end    = 14'(col_ff) + 14'(size);
   assign outside    = (row_ff >= rows_e) || (col_ff >= cols_e);
   assign forced     = (size > SIZE_W'(1)) && !at_max &&
                       ((size > SIZE_W'(maxb_e)) || (row_end > 14'(rows_e)) ||
                        (col_end > 14'(cols_e)));
   assign want_split = (size > SIZE_W'(minb_e)) && !at_max;

   // Top of the child stack.
   logic [LW-1:0] lvl_m1;
   logic [IW-1:0] top_idx, push_idx;
   logic [1:0]    kid;

   assign lvl_m1   = level_ff - LW'(1);
   assign top_idx  = lvl_m1[IW-1:0];
   assign push_idx = level_ff[IW-1:0];
   assign kid      = stack_ff[top_idx];

   // Field assembly for the bit at the head of the shifter.
   logic               bit_cur;
   logic [FIELD_W-1:0] acc_new;
   logic [4:0]         idx_new;
   logic [3:0]         fwidth;
   logic               complete;
   phase_type          np_raw, np;
   logic [17:0]        dom_prod;

   assign bit_cur  = buf_ff[7];
   assign acc_new  = acc_ff | (FIELD_W'(bit_cur) << idx_ff);
   assign idx_new  = 5'(idx_ff) + 5'd1;
   assign complete = (idx_new >= 5'(fwidth));
   assign dom_prod = 18'(acc_new[11:0]) * 18'(step_e);

   always_comb begin
      case (phase_ff)
         PH_SCALE:  fwidth = sbits_e;
         PH_OFFSET: fwidth = obits_e;
         PH_U:      fwidth = 4'd8;
         PH_V:      fwidth = 4'd8;
         PH_ISO:    fwidth = 4'd3;
         PH_DROW:   fwidth = wrow_ff;
         PH_DCOL:   fwidth = wcol_ff;
         default:   fwidth = 4'd0;
      endcase
   end

   // Phase that follows a completed field, zero-width coordinates skipped.
   always_comb begin
      case (phase_ff)
         PH_SCALE:  np_raw = PH_OFFSET;
         PH_OFFSET: np_raw = cfg.color_mode ? PH_U :
                             ((scale_ff != '0) ? PH_ISO : PH_EMIT);
         PH_U:      np_raw = PH_V;
         PH_V:      np_raw = (scale_ff != '0) ? PH_ISO : PH_EMIT;
         PH_ISO:    np_raw = PH_DROW;
         PH_DROW:   np_raw = PH_DCOL;
         default:   np_raw = PH_EMIT;
      endcase
      np = np_raw;
      if (np == PH_DROW && wrow_ff == '0) begin
         np = (wcol_ff == '0) ? PH_EMIT : PH_DCOL;
      end else if (np == PH_DCOL && wcol_ff == '0) begin
         np = PH_EMIT;
      end
   end

   // Sweep candidates for the root exponent and the coordinate widths.
   logic [12:0] pow_n;
   logic [19:0] lim_n;

   assign pow_n = 13'(1) << sweep_ff;
   assign lim_n = (20'(step_e) << sweep_ff) + 20'(step_e);

   // Status towards the controller.
   always_comb begin
      if (done_ff)         sts.settle_kind = SK_DONE;
      else if (outside)    sts.settle_kind = SK_OUT;
      else if (forced)     sts.settle_kind = SK_DESCEND;
      else                 sts.settle_kind = SK_STOP;
      if (level_ff == '0)  sts.adv_kind = AK_DONE;
      else if (kid == 2'd3) sts.adv_kind = AK_POP;
      else                 sts.adv_kind = AK_STEP;
      if (phase_ff == PH_SPLIT) begin
         sts.bit_kind = bit_cur ? BK_DESCEND : BK_NEXT;
      end else begin
         sts.bit_kind = (complete && np == PH_EMIT) ? BK_EMIT : BK_NEXT;
      end
      sts.bits_left  = (rem_ff != '0);
      sts.bits_last  = (rem_ff == 4'd1);
      sts.walk_done  = done_ff;
      sts.out_busy   = ovalid_ff;
      sts.sweep_last = (sweep_ff == SWEEP_LAST);
   end

   // Next-state logic for the operation in hand.
   always_comb begin
      buf_in   = buf_ff;   rem_in   = rem_ff;   acc_in   = acc_ff;
      idx_in   = idx_ff;   phase_in = phase_ff; stack_in = stack_ff;
      level_in = level_ff; row_in   = row_ff;   col_in   = col_ff;
      done_in  = done_ff;  scale_in = scale_ff; offs_in  = offs_ff;
      chroma_in = chroma_ff; iso_in = iso_ff;   drow_in  = drow_ff;
      dcol_in  = dcol_ff;  sweep_in = sweep_ff; exp_in   = exp_ff;
      wrow_in  = wrow_ff;  wcol_in  = wcol_ff;  expf_in  = expf_ff;
      wrowf_in = wrowf_ff; wcolf_in = wcolf_ff;
      orow_in  = orow_ff;  ocol_in  = ocol_ff;  osize_in = osize_ff;
      oscale_in = oscale_ff; ooffs_in = ooffs_ff; ochroma_in = ochroma_ff;
      oiso_in  = oiso_ff;  odrow_in = odrow_ff; odcol_in = odcol_ff;
      olast_in = olast_ff;
      ovalid_in = ovalid_ff && rsp_stall;

      case (cmd.op)
         OP_CLEAR: begin
            buf_in = '0; rem_in = '0; acc_in = '0; idx_in = '0;
            phase_in = PH_SPLIT;
            for (int i = 0; i < MAX_LEVELS; i++) stack_in[i] = 2'd0;
            level_in = '0; row_in = '0; col_in = '0; done_in = 1'b0;
            scale_in = '0; offs_in = '0; chroma_in = '0; iso_in = '0;
            drow_in = '0; dcol_in = '0;
            sweep_in = '0; exp_in = '0; wrow_in = '0; wcol_in = '0;
            expf_in = 1'b0; wrowf_in = 1'b0; wcolf_in = 1'b0;
         end
         OP_SWEEP: begin
            if (!expf_ff && pow_n >= 13'(span)) begin
               exp_in = sweep_ff; expf_in = 1'b1;
            end
            if (!wrowf_ff && 20'(rows_e) < lim_n) begin
               wrow_in = sweep_ff; wrowf_in = 1'b1;
            end
            if (!wcolf_ff && 20'(cols_e) < lim_n) begin
               wcol_in = sweep_ff; wcolf_in = 1'b1;
            end
            sweep_in = sweep_ff + 4'd1;
         end
         OP_SETTLE: begin
            if (sts.settle_kind == SK_DESCEND) begin
               stack_in[push_idx] = 2'd0;
               level_in = level_ff + LW'(1);
            end else if (sts.settle_kind == SK_STOP) begin
               if (want_split) begin
                  phase_in = PH_SPLIT;
               end else begin
                  scale_in = '0; offs_in = '0; chroma_in = '0; iso_in = '0;
                  drow_in = '0; dcol_in = '0; acc_in = '0; idx_in = '0;
                  phase_in = PH_SCALE;
               end
            end
         end
         OP_ADVANCE: begin
            case (sts.adv_kind)
               AK_DONE: begin
                  done_in = 1'b1; phase_in = PH_DONE;
               end
               AK_STEP: begin
                  stack_in[top_idx] = kid + 2'd1;
                  row_in = kid[0] ? (row_ff - half) : (row_ff + half);
                  if (kid == 2'd1) col_in = col_ff + half;
               end
               default: begin
                  row_in = row_ff - half;
                  col_in = col_ff - half;
                  level_in = lvl_m1;
               end
            endcase
         end
         OP_LOAD: begin
            buf_in = req_stream_byte;
            rem_in = 4'd8;
         end
         OP_BIT: begin
            buf_in = {buf_ff[6:0], 1'b0};
            rem_in = rem_ff - 4'd1;
            if (phase_ff == PH_SPLIT) begin
               if (bit_cur) begin
                  stack_in[push_idx] = 2'd0;
                  level_in = level_ff + LW'(1);
               end else begin
                  scale_in = '0; offs_in = '0; chroma_in = '0; iso_in = '0;
                  drow_in = '0; dcol_in = '0; acc_in = '0; idx_in = '0;
                  phase_in = PH_SCALE;
               end
            end else if (complete) begin
               case (phase_ff)
                  PH_SCALE:  scale_in = acc_new;
                  PH_OFFSET: offs_in = acc_new;
                  PH_U:      chroma_in[7:0] = acc_new[7:0];
                  PH_V:      chroma_in[15:8] = acc_new[7:0];
                  PH_ISO:    iso_in = acc_new[2:0];
                  PH_DROW:   drow_in = dom_prod;
                  PH_DCOL:   dcol_in = dom_prod;
                  default:   acc_in = '0;
               endcase
               acc_in = '0; idx_in = '0; phase_in = np;
            end else begin
               acc_in = acc_new; idx_in = idx_new[3:0];
            end
         end
         OP_EMIT: begin
            orow_in = row_ff; ocol_in = col_ff; osize_in = size[6:0];
            oscale_in = scale_ff; ooffs_in = offs_ff; ochroma_in = chroma_ff;
            oiso_in = iso_ff; odrow_in = drow_ff; odcol_in = dcol_ff;
         end
         default: begin
            buf_in = buf_ff;
         end
      endcase

      // A record is shown once the walk has moved past it.
      if (cmd.show) begin
         ovalid_in = 1'b1;
         olast_in  = done_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff    <= '0;
         level_ff  <= '0;
         done_ff   <= 1'b0;
         ovalid_ff <= 1'b0;
         sweep_ff  <= '0;
      end else begin
         rem_ff    <= rem_in;
         level_ff  <= level_in;
         done_ff   <= done_in;
         ovalid_ff <= ovalid_in;
         sweep_ff  <= sweep_in;
      end
      buf_ff <= buf_in;   acc_ff <= acc_in;     idx_ff <= idx_in;
      phase_ff <= phase_in; stack_ff <= stack_in;
      row_ff <= row_in;   col_ff <= col_in;
      scale_ff <= scale_in; offs_ff <= offs_in; chroma_ff <= chroma_in;
      iso_ff <= iso_in;   drow_ff <= drow_in;   dcol_ff <= dcol_in;
      exp_ff <= exp_in;   wrow_ff <= wrow_in;   wcol_ff <= wcol_in;
      expf_ff <= expf_in; wrowf_ff <= wrowf_in; wcolf_ff <= wcolf_in;
      orow_ff <= orow_in; ocol_ff <= ocol_in;   osize_ff <= osize_in;
      oscale_ff <= oscale_in; ooffs_ff <= ooffs_in; ochroma_ff <= ochroma_in;
      oiso_ff <= oiso_in; odrow_ff <= odrow_in; odcol_ff <= odcol_in;
      olast_ff <= olast_in;
   end

   assign rsp_valid       = ovalid_ff;
   assign rsp_block_row   = orow_ff;
   assign rsp_block_col   = ocol_ff;
   assign rsp_block_size  = osize_ff;
   assign rsp_scale_code  = oscale_ff;
   assign rsp_offset_code = ooffs_ff;
   assign rsp_chroma_u    = ochroma_ff[7:0];
   assign rsp_chroma_v    = ochroma_ff[15:8];
   assign rsp_isometry    = oiso_ff;
   assign rsp_domain_row  = odrow_ff;
   assign rsp_domain_col  = odcol_ff;
   assign rsp_last        = olast_ff;

   // The tree never goes deeper than its bound.
   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      level_ff <= LW'(MAX_LEVELS))
      else $error("tree level beyond bound");

   // A record is never captured over one still waiting at the output.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_EMIT) |-> !ovalid_ff)
      else $error("result register overwritten");

   // Bits are only consumed while the shifter holds some.
   a_bits_present: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_BIT) |-> (rem_ff != '0 && rem_ff <= 4'd8))
      else $error("bit taken from an empty shifter");

endmodule

### rtl/qfcp_ctrl.sv
// ----------------------------------------------------------------------------
// Quadtree fractal code parser controller
// Sequences the datapath: restart sweep, tree settling, bit consumption and
// record emission, and decides when a new request byte may be taken.
// ----------------------------------------------------------------------------
module qfcp_ctrl
   import qfcp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    csr_write,
   input  sts_type sts,
   output cmd_type cmd,
   output logic    req_take
);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_SWEEP,
      S_SETTLE,
      S_ADVANCE,
      S_IDLE,
      S_BITS,
      S_EMIT,
      S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      from_emit_ff, from_emit_in;

   always_comb begin
      state_in     = state_ff;
      from_emit_in = from_emit_ff;
      cmd.op       = OP_NONE;
      cmd.show     = 1'b0;
      req_take     = 1'b0;

      case (state_ff)
         S_CLEAR: begin
            cmd.op   = OP_CLEAR;
            state_in = S_SWEEP;
         end
         S_SWEEP: begin
            cmd.op = OP_SWEEP;
            if (sts.sweep_last) begin
               state_in     = S_SETTLE;
               from_emit_in = 1'b0;
            end
         end
         S_SETTLE: begin
            cmd.op = OP_SETTLE;
            case (sts.settle_kind)
               SK_OUT:     state_in = S_ADVANCE;
               SK_DESCEND: state_in = S_SETTLE;
               default: begin
                  // Walk has settled on a node or finished.
                  cmd.show     = from_emit_ff;
                  from_emit_in = 1'b0;
                  if (sts.walk_done)      state_in = S_DONE;
                  else if (sts.bits_left) state_in = S_BITS;
                  else                    state_in = S_IDLE;
               end
            endcase
         end
         S_ADVANCE: begin
            cmd.op = OP_ADVANCE;
            if (sts.adv_kind != AK_POP) state_in = S_SETTLE;
         end
         S_IDLE: begin
            req_take = 1'b1;
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = S_BITS;
            end
         end
         S_BITS: begin
            cmd.op = OP_BIT;
            case (sts.bit_kind)
               BK_DESCEND: state_in = S_SETTLE;
               BK_EMIT:    state_in = S_EMIT;
               default: begin
                  if (sts.bits_last) state_in = S_IDLE;
               end
            endcase
         end
         S_EMIT: begin
            if (!sts.out_busy) begin
               cmd.op       = OP_EMIT;
               from_emit_in = 1'b1;
               state_in     = S_ADVANCE;
            end
         end
         S_DONE: begin
            // Later bytes are taken and dropped.
            req_take = 1'b1;
         end
         default: state_in = S_CLEAR;
      endcase

      if (csr_write) state_in = S_CLEAR;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         from_emit_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         from_emit_ff <= from_emit_in;
      end
   end

endmodule

### rtl/quadtree_fractal_code_parser.sv
// ----------------------------------------------------------------------------
// Quadtree fractal code parser
// Walks a quadtree fractal code stream byte by byte and emits one transform
// record for each leaf of the tree.
//
//   Channel  Direction  Handshake                Payload
//   req      in         req_valid / req_stall    req_stream_byte
//   rsp      out        rsp_valid / rsp_stall    block position, size, codes
//   csr      in/out     psel, penable, pready    paddr, pwdata, prdata
//
// A byte is loaded into the shifter and then taken one bit per cycle,
// with the walk pausing for each descent or settling step, for each stack
// move when a record ends the node, and to capture each record.
// After reset or any register write the block clears its state and runs
// its exponent sweep, then settles at the root before it takes a byte.
// A stalled result holds the walk only when the next record is ready.
// ----------------------------------------------------------------------------
module quadtree_fractal_code_parser
   import qfcp_pkg::*;
#(
   parameter int MAX_LEVELS = DEF_MAX_LEVELS
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [7:0]            req_stream_byte,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [COORD_W-1:0]    rsp_block_row,
   output logic [COORD_W-1:0]    rsp_block_col,
   output logic [6:0]            rsp_block_size,
   output logic [FIELD_W-1:0]    rsp_scale_code,
   output logic [FIELD_W-1:0]    rsp_offset_code,
   output logic [7:0]            rsp_chroma_u,
   output logic [7:0]            rsp_chroma_v,
   output logic [2:0]            rsp_isometry,
   output logic [DOM_W-1:0]      rsp_domain_row,
   output logic [DOM_W-1:0]      rsp_domain_col,
   output logic                  rsp_last,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   cfg_type cfg;
   cmd_type cmd;
   sts_type sts;
   logic    csr_write;
   logic    req_take;

   assign req_stall = !req_take;

   // Configuration registers.
   qfcp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready),
      .cfg       (cfg),
      .csr_write (csr_write)
   );

   // Sequencer.
   qfcp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .csr_write (csr_write),
      .sts       (sts),
      .cmd       (cmd),
      .req_take  (req_take)
   );

   // Datapath and result register.
   qfcp_dp #(
      .MAX_LEVELS (MAX_LEVELS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .cmd             (cmd),
      .req_stream_byte (req_stream_byte),
      .rsp_stall       (rsp_stall),
      .sts             (sts),
      .rsp_valid       (rsp_valid),
      .rsp_block_row   (rsp_block_row),
      .rsp_block_col   (rsp_block_col),
      .rsp_block_size  (rsp_block_size),
      .rsp_scale_code  (rsp_scale_code),
      .rsp_offset_code (rsp_offset_code),
      .rsp_chroma_u    (rsp_chroma_u),
      .rsp_chroma_v    (rsp_chroma_v),
      .rsp_isometry    (rsp_isometry),
      .rsp_domain_row  (rsp_domain_row),
      .rsp_domain_col  (rsp_domain_col),
      .rsp_last        (rsp_last)
   );

endmodule
